@@ hw/rtl/mxn_pkg.sv @@
// Shared types and constants for the mutual exclusion node.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mxn_pkg;

  localparam int ID_W       = 4;
  localparam int NC_W       = 5;
  localparam int TIME_W     = 16;
  localparam int CMD_W      = 2;
  localparam int REPLY_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam int DEF_MAX_NODES  = 16;
  localparam int DEF_CLOCK_BITS = 16;
  localparam int FIFO_DEPTH     = 2;

  localparam logic [ID_W-1:0]    OWN_ID_RST     = 4'd0;
  localparam logic [NC_W-1:0]    NODE_COUNT_RST = 5'd3;
  localparam logic [NC_W-1:0]    MIN_NODES      = 5'd2;
  localparam logic [REPLY_W-1:0] REPLY_MAX      = 4'd15;

  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MESSAGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic MSG_REQUEST = 1'b0;
  localparam logic MSG_REPLY   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;

  typedef enum logic [1:0] {
    JOB_SINGLE,
    JOB_BCAST,
    JOB_FLUSH
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic              has_send;
    logic              send_kind;
    logic [ID_W-1:0]   dest;
    logic [TIME_W-1:0] stamp;
    logic              granted;
    logic [ID_W-1:0]   own_id;
    logic [NC_W-1:0]   nodes;
  } job_t;

endpackage

@@ hw/rtl/mxn_fifo.sv @@
// Small two-entry queue between the front and back of the node.
// Depends on mxn_pkg for the queue depth.
module mxn_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW    = $clog2(mxn_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(mxn_pkg::FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [mxn_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(mxn_pkg::FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

@@ hw/rtl/mxn_front.sv @@
// Front part of the node: configuration registers, Lamport clock, phase,
// reply count and deferred sender list; turns each event into a job. Uses mxn_pkg.
module mxn_front #(
  parameter int MAX_NODES  = mxn_pkg::DEF_MAX_NODES,
  parameter int CLOCK_BITS = mxn_pkg::DEF_CLOCK_BITS,
  localparam int QW = $clog2(MAX_NODES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mxn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mxn_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [mxn_pkg::CMD_W-1:0]           cmd,
  input  logic                                msg_kind,
  input  logic [mxn_pkg::TIME_W-1:0]          msg_time,
  input  logic [mxn_pkg::ID_W-1:0]            sender,
  output logic                                job_valid,
  input  logic                                job_ready,
  output mxn_pkg::job_t                       job,
  output logic [QW-1:0]                       job_count,
  output logic [MAX_NODES*mxn_pkg::ID_W-1:0]  job_ids
);

  localparam int CW    = CLOCK_BITS;
  localparam int CMP_W = (CW > mxn_pkg::TIME_W) ? CW : mxn_pkg::TIME_W;
  localparam logic [CW-1:0]    CMAX   = {CW{1'b1}};
  localparam logic [CMP_W-1:0] CMAX_W = CMP_W'(CMAX);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_REQ,
    PH_CS
  } phase_t;

  logic [mxn_pkg::ID_W-1:0]    own_id;
  logic [mxn_pkg::NC_W-1:0]    node_count;
  phase_t                      phase;
  phase_t                      phase_next;
  logic [CW-1:0]               lamport_clock;
  logic [CW-1:0]               lamport_clock_next;
  logic [CW-1:0]               request_time;
  logic [CW-1:0]               request_time_next;
  logic [mxn_pkg::REPLY_W-1:0] reply_count;
  logic [mxn_pkg::REPLY_W-1:0] reply_count_next;
  logic [QW-1:0]               dcount;
  logic [QW-1:0]               dcount_next;
  logic [mxn_pkg::ID_W-1:0]    defer_ids [MAX_NODES];
  logic                        defer_we;

  logic                        accept;
  logic [mxn_pkg::NC_W-1:0]    nodes;
  logic [CW-1:0]               tick;
  logic [CMP_W-1:0]            mt_w;
  logic [CMP_W-1:0]            clk_w;
  logic [CMP_W-1:0]            mx;
  logic [CW-1:0]               mx_c;
  logic [CW-1:0]               msg_clk;
  logic                        prio;
  logic [mxn_pkg::REPLY_W-1:0] rc_inc;

  assign cfg_ready  = 1'b1;
  assign job_valid  = item_valid;
  assign item_ready = job_ready;
  assign accept     = item_valid && job_ready;
  assign job_count  = dcount;

  always_comb begin
    if (node_count < mxn_pkg::MIN_NODES) begin
      nodes = mxn_pkg::MIN_NODES;
    end else if (int'(node_count) > MAX_NODES) begin
      nodes = mxn_pkg::NC_W'(MAX_NODES);
    end else begin
      nodes = node_count;
    end
  end

  assign tick  = (lamport_clock == CMAX) ? lamport_clock : lamport_clock + CW'(1);
  assign mt_w  = CMP_W'(msg_time);
  assign clk_w = CMP_W'(lamport_clock);
  assign mx    = (mt_w > clk_w) ? ((mt_w > CMAX_W) ? CMAX_W : mt_w) : clk_w;
  assign mx_c  = mx[CW-1:0];
  assign msg_clk = (mx_c == CMAX) ? mx_c : mx_c + CW'(1);
  assign prio  = (mt_w < CMP_W'(request_time)) ||
                 ((mt_w == CMP_W'(request_time)) && (sender < own_id));
  assign rc_inc = (reply_count < mxn_pkg::REPLY_MAX) ?
                  reply_count + mxn_pkg::REPLY_W'(1) : reply_count;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      job_ids[i*mxn_pkg::ID_W +: mxn_pkg::ID_W] = defer_ids[i];
    end
  end

  always_comb begin
    phase_next         = phase;
    lamport_clock_next = lamport_clock;
    request_time_next  = request_time;
    reply_count_next   = reply_count;
    dcount_next        = dcount;
    defer_we           = 1'b0;
    job                = '0;
    job.kind           = mxn_pkg::JOB_SINGLE;
    job.own_id         = own_id;
    job.nodes          = nodes;
    case (cmd)
      mxn_pkg::CMD_REQUEST: begin
        if (phase == PH_IDLE) begin
          lamport_clock_next = tick;
          request_time_next  = tick;
          reply_count_next   = '0;
          phase_next         = PH_REQ;
          job.kind           = mxn_pkg::JOB_BCAST;
          job.stamp          = mxn_pkg::TIME_W'(tick);
        end
      end
      mxn_pkg::CMD_MESSAGE: begin
        lamport_clock_next = msg_clk;
        if (msg_kind == mxn_pkg::MSG_REQUEST) begin
          if (phase == PH_IDLE || (phase == PH_REQ && prio)) begin
            job.has_send  = 1'b1;
            job.send_kind = mxn_pkg::MSG_REPLY;
            job.dest      = sender;
            job.stamp     = mxn_pkg::TIME_W'(msg_clk);
          end else if (dcount < QW'(MAX_NODES - 1)) begin
            defer_we    = 1'b1;
            dcount_next = dcount + QW'(1);
          end
        end else if (phase == PH_REQ) begin
          reply_count_next = rc_inc;
          if (mxn_pkg::NC_W'(rc_inc) >= nodes - mxn_pkg::NC_W'(1)) begin
            phase_next  = PH_CS;
            job.granted = 1'b1;
          end
        end
      end
      mxn_pkg::CMD_RELEASE: begin
        if (phase == PH_CS) begin
          lamport_clock_next = tick;
          dcount_next        = '0;
          phase_next         = PH_IDLE;
          job.kind           = mxn_pkg::JOB_FLUSH;
          job.stamp          = mxn_pkg::TIME_W'(tick);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id        <= mxn_pkg::OWN_ID_RST;
      node_count    <= mxn_pkg::NODE_COUNT_RST;
      phase         <= PH_IDLE;
      lamport_clock <= '0;
      request_time  <= '0;
      reply_count   <= '0;
      dcount        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mxn_pkg::CFG_OWN_ID) begin
          own_id <= cfg_data[mxn_pkg::ID_W-1:0];
        end else if (cfg_index == mxn_pkg::CFG_NODE_COUNT) begin
          node_count <= cfg_data[mxn_pkg::NC_W-1:0];
        end
      end
      if (accept) begin
        phase         <= phase_next;
        lamport_clock <= lamport_clock_next;
        request_time  <= request_time_next;
        reply_count   <= reply_count_next;
        dcount        <= dcount_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && defer_we) begin
      defer_ids[dcount] <= sender;
    end
  end

  a_flush_idles: assert property (@(posedge clk) disable iff (rst)
    accept && job.kind == mxn_pkg::JOB_FLUSH |=> phase == PH_IDLE && dcount == '0)
    else $error("release did not return the node to idle with an empty list");

  a_defer_bound: assert property (@(posedge clk) disable iff (rst)
    accept && defer_we |-> dcount < QW'(MAX_NODES - 1))
    else $error("deferred list written beyond its capacity");

endmodule

@@ hw/rtl/mxn_back.sv @@
// Back part of the node: expands each job into result transactions and
// holds them in an output register. Uses mxn_pkg.
module mxn_back #(
  parameter int MAX_NODES = mxn_pkg::DEF_MAX_NODES,
  localparam int QW = $clog2(MAX_NODES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  mxn_pkg::job_t                       job,
  input  logic [QW-1:0]                       job_count,
  input  logic [MAX_NODES*mxn_pkg::ID_W-1:0]  job_ids,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                has_send,
  output logic                                send_kind,
  output logic [mxn_pkg::ID_W-1:0]            dest,
  output logic [mxn_pkg::TIME_W-1:0]          send_time,
  output logic                                granted,
  output logic                                last
);

  logic                        active;
  mxn_pkg::job_t               cur;
  logic [QW-1:0]               cur_count;
  logic [mxn_pkg::ID_W-1:0]    cur_ids [MAX_NODES];
  logic [mxn_pkg::NC_W-1:0]    bcast_idx;
  logic [mxn_pkg::NC_W-1:0]    sent;
  logic [QW-1:0]               flush_idx;

  logic                        out_free;
  logic                        load;
  logic                        emit;
  logic                        skip;
  logic                        e_has_send;
  logic                        e_send_kind;
  logic [mxn_pkg::ID_W-1:0]    e_dest;
  logic [mxn_pkg::TIME_W-1:0]  e_time;
  logic                        e_granted;
  logic                        e_last;

  assign job_ready = !active;
  assign load      = job_valid && !active;
  assign out_free  = !result_valid || result_ready;

  always_comb begin
    emit        = 1'b0;
    skip        = 1'b0;
    e_has_send  = 1'b0;
    e_send_kind = 1'b0;
    e_dest      = '0;
    e_time      = '0;
    e_granted   = 1'b0;
    e_last      = 1'b0;
    if (active && out_free) begin
      case (cur.kind)
        mxn_pkg::JOB_BCAST: begin
          if (bcast_idx == mxn_pkg::NC_W'(cur.own_id)) begin
            skip = 1'b1;
          end else begin
            emit        = 1'b1;
            e_has_send  = 1'b1;
            e_send_kind = mxn_pkg::MSG_REQUEST;
            e_dest      = bcast_idx[mxn_pkg::ID_W-1:0];
            e_time      = cur.stamp;
            e_last      = (sent == cur.nodes - mxn_pkg::NC_W'(2));
          end
        end
        mxn_pkg::JOB_FLUSH: begin
          emit = 1'b1;
          if (cur_count == '0) begin
            e_last = 1'b1;
          end else begin
            e_has_send  = 1'b1;
            e_send_kind = mxn_pkg::MSG_REPLY;
            e_dest      = cur_ids[flush_idx];
            e_time      = cur.stamp;
            e_last      = (flush_idx == cur_count - QW'(1));
          end
        end
        default: begin
          emit        = 1'b1;
          e_has_send  = cur.has_send;
          e_send_kind = cur.send_kind;
          e_dest      = cur.dest;
          e_time      = cur.stamp;
          e_granted   = cur.granted;
          e_last      = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      result_valid <= 1'b0;
      bcast_idx    <= '0;
      sent         <= '0;
      flush_idx    <= '0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
        if (e_last) begin
          active <= 1'b0;
        end
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (skip || (emit && cur.kind == mxn_pkg::JOB_BCAST)) begin
        bcast_idx <= bcast_idx + mxn_pkg::NC_W'(1);
      end
      if (emit && cur.kind == mxn_pkg::JOB_BCAST) begin
        sent <= sent + mxn_pkg::NC_W'(1);
      end
      if (emit && cur.kind == mxn_pkg::JOB_FLUSH) begin
        flush_idx <= flush_idx + QW'(1);
      end
      if (load) begin
        active    <= 1'b1;
        bcast_idx <= '0;
        sent      <= '0;
        flush_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur       <= job;
      cur_count <= job_count;
      for (int i = 0; i < MAX_NODES; i++) begin
        cur_ids[i] <= job_ids[i*mxn_pkg::ID_W +: mxn_pkg::ID_W];
      end
    end
    if (emit) begin
      has_send  <= e_has_send;
      send_kind <= e_send_kind;
      dest      <= e_dest;
      send_time <= e_time;
      granted   <= e_granted;
      last      <= e_last;
    end
  end

  a_load_active: assert property (@(posedge clk) disable iff (rst)
    load |=> active)
    else $error("job taken from the queue but sequencer not active");

  a_bcast_bound: assert property (@(posedge clk) disable iff (rst)
    active && cur.kind == mxn_pkg::JOB_BCAST |-> sent < cur.nodes - mxn_pkg::NC_W'(1))
    else $error("broadcast sent more requests than there are peers");

  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    active && cur.kind == mxn_pkg::JOB_FLUSH && cur_count != '0 |-> flush_idx < cur_count)
    else $error("deferred reply index ran past the list");

endmodule

@@ hw/rtl/mutual_exclusion_node_unit.sv @@
// Top level of one Ricart-Agrawala mutual exclusion node with a Lamport clock.
// Built from mxn_front, mxn_fifo and mxn_back; uses mxn_pkg.
//
// Channels: the event channel (item_valid/item_ready with cmd, msg_kind,
// msg_time, sender) carries local requests, received messages and releases.
// The result channel (result_valid/result_ready) carries one transaction per
// message to send or grant, with last set on the final one of each event;
// an event that causes nothing gives one empty transaction with last set.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// own_id (index 0) and node_count (index 1); it is always ready.
// The front takes one event per cycle while the two-entry job queue has room.
// An accepted event enters the job queue; the back, when idle, loads it into
// its job register, then places each result in the output register, passing
// over own_id in a broadcast, and takes no new job until the last is out: a
// request gives node_count-1 results (node_count held to 2..MAX_NODES), a
// release one per deferred sender (one empty if none), other events one.
// Reset clears the clock, phase, counts and queue; no clearing pass is needed.
// When the receiver stalls, the output register holds its transaction, the
// queue fills, and then the event channel stalls.
module mutual_exclusion_node_unit #(
  parameter int MAX_NODES  = mxn_pkg::DEF_MAX_NODES,
  parameter int CLOCK_BITS = mxn_pkg::DEF_CLOCK_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mxn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mxn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [mxn_pkg::CMD_W-1:0]      cmd,
  input  logic                           msg_kind,
  input  logic [mxn_pkg::TIME_W-1:0]     msg_time,
  input  logic [mxn_pkg::ID_W-1:0]       sender,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           has_send,
  output logic                           send_kind,
  output logic [mxn_pkg::ID_W-1:0]       dest,
  output logic [mxn_pkg::TIME_W-1:0]     send_time,
  output logic                           granted,
  output logic                           last
);

  localparam int QW    = $clog2(MAX_NODES);
  localparam int IDS_W = MAX_NODES * mxn_pkg::ID_W;
  localparam int JOB_W = $bits(mxn_pkg::job_t);
  localparam int FW    = JOB_W + QW + IDS_W;

  logic                 f_valid;
  logic                 f_ready;
  mxn_pkg::job_t        f_job;
  logic [QW-1:0]        f_count;
  logic [IDS_W-1:0]     f_ids;
  logic [FW-1:0]        q_in;
  logic [FW-1:0]        q_out;
  logic                 b_valid;
  logic                 b_ready;
  mxn_pkg::job_t        b_job;
  logic [QW-1:0]        b_count;
  logic [IDS_W-1:0]     b_ids;

  mxn_front #(
    .MAX_NODES  (MAX_NODES),
    .CLOCK_BITS (CLOCK_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .msg_kind   (msg_kind),
    .msg_time   (msg_time),
    .sender     (sender),
    .job_valid  (f_valid),
    .job_ready  (f_ready),
    .job        (f_job),
    .job_count  (f_count),
    .job_ids    (f_ids)
  );

  assign q_in = {f_job, f_count, f_ids};

  mxn_fifo #(
    .WIDTH (FW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (q_in),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (q_out)
  );

  assign b_job   = mxn_pkg::job_t'(q_out[FW-1 -: JOB_W]);
  assign b_count = q_out[IDS_W +: QW];
  assign b_ids   = q_out[IDS_W-1:0];

  mxn_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (b_valid),
    .job_ready    (b_ready),
    .job          (b_job),
    .job_count    (b_count),
    .job_ids      (b_ids),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .has_send     (has_send),
    .send_kind    (send_kind),
    .dest         (dest),
    .send_time    (send_time),
    .granted      (granted),
    .last         (last)
  );

endmodule
